/* rtl/rlcf_pkg.sv */
// Shared types, codes and constants for the RGB LED command and fade block.
// No dependencies; imported by every module of the block.
package rlcf_pkg;

    localparam int unsigned LEVEL_W = 7;
    localparam int unsigned RESP_W  = 3;
    localparam int unsigned IDX_W   = 3;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 7'd99;
    localparam logic [LEVEL_W-1:0] LEVEL_PRE_MAX = 7'd98;
    localparam logic [IDX_W-1:0]   LAST_MASK_IDX = 3'd6;

    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_D_LOW   = 8'h64;
    localparam logic [7:0] CHAR_D_UP    = 8'h44;
    localparam logic [7:0] CHAR_R_LOW   = 8'h72;
    localparam logic [7:0] CHAR_R_UP    = 8'h52;
    localparam logic [7:0] CHAR_G_LOW   = 8'h67;
    localparam logic [7:0] CHAR_G_UP    = 8'h47;
    localparam logic [7:0] CHAR_B_LOW   = 8'h62;
    localparam logic [7:0] CHAR_B_UP    = 8'h42;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_NINE    = 8'h39;

    typedef enum logic [RESP_W-1:0] {
        RESP_NONE     = 3'd0,
        RESP_DEMO_ON  = 3'd1,
        RESP_DEMO_OFF = 3'd2,
        RESP_IGNORED  = 3'd3,
        RESP_RED_OK   = 3'd4,
        RESP_GREEN_OK = 3'd5,
        RESP_BLUE_OK  = 3'd6,
        RESP_INVALID  = 3'd7
    } resp_t;

    typedef enum logic [2:0] {
        CMD_EMPTY = 3'd0,
        CMD_DEMO  = 3'd1,
        CMD_RED   = 3'd2,
        CMD_GREEN = 3'd3,
        CMD_BLUE  = 3'd4,
        CMD_BAD   = 3'd5
    } cmd_kind_t;

    typedef struct packed {
        logic               term;
        cmd_kind_t          kind;
        logic [LEVEL_W-1:0] value;
    } cmd_dec_t;

    typedef struct packed {
        logic tick;
        logic restart;
    } fade_ctl_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [2:0]         mask;
    } fade_out_t;

    // Colour mask sequence: bit 0 red, bit 1 green, bit 2 blue.
    function automatic logic [2:0] colour_mask(input logic [IDX_W-1:0] idx);
        logic [2:0] m;
        case (idx)
            3'd0:    m = 3'b001;
            3'd1:    m = 3'b010;
            3'd2:    m = 3'b100;
            3'd3:    m = 3'b011;
            3'd4:    m = 3'b110;
            3'd5:    m = 3'b101;
            3'd6:    m = 3'b111;
            default: m = 3'b001;
        endcase
        return m;
    endfunction

endpackage

/* rtl/rgb_led_command_and_fade.sv */
// RGB LED command interpreter with demo fade. Each transaction on the s_
// channel is a received character (s_command = 0) or a fade tick
// (s_command = 1); each yields exactly one m_ transaction carrying the three
// duties now applied, a response code and the demo flag. Characters build a
// command of up to BUFFER_DEPTH bytes, ended by LF or CR: d/D toggles demo
// mode, r/g/b (either case) plus two decimal digits sets a duty 0..99. A
// character past BUFFER_DEPTH bytes discards the command. Timing: an accepted
// transaction sits in the input register; the combinational decode and
// update then writes state and the result register together, held off while
// the result register is full and m_ready is low. One transaction per cycle
// is sustained while m_ready is high; s_ready drops only while both the input
// register and the result register are full and m_ready is low.
// Depends on rlcf_pkg, rlcf_cmd and rlcf_fade.
module rgb_led_command_and_fade
    import rlcf_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_command,
    input  logic [7:0]         s_char_code,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [LEVEL_W-1:0] m_red_level,
    output logic [LEVEL_W-1:0] m_green_level,
    output logic [LEVEL_W-1:0] m_blue_level,
    output logic [RESP_W-1:0]  m_response,
    output logic               m_demo_active
);

    // Input register
    logic       in_valid_reg, in_valid_next;
    logic       cmd_reg;
    logic [7:0] char_reg;

    // Result register; the shown levels and demo flag double as result payload
    logic               out_valid_reg, out_valid_next;
    resp_t              resp_reg, resp_next;
    logic [LEVEL_W-1:0] red_reg, red_next;
    logic [LEVEL_W-1:0] green_reg, green_next;
    logic [LEVEL_W-1:0] blue_reg, blue_next;
    logic               demo_reg, demo_next;

    // Set duties
    logic [LEVEL_W-1:0] set_red_reg, set_red_next;
    logic [LEVEL_W-1:0] set_green_reg, set_green_next;
    logic [LEVEL_W-1:0] set_blue_reg, set_blue_next;

    logic      s_accept;
    logic      advance;
    cmd_dec_t  dec;
    fade_ctl_t fade_ctl;
    fade_out_t fade_out;

    // Advance the held transaction whenever the result slot is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg  <= s_command;
            char_reg <= s_char_code;
        end
    end

    rlcf_cmd #(
        .BUFFER_DEPTH(BUFFER_DEPTH)
    ) u_cmd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance && !cmd_reg),
        .char_code (char_reg),
        .dec       (dec)
    );

    rlcf_fade u_fade (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (fade_ctl),
        .fout    (fade_out)
    );

    // Main update: tick drives the fade, a terminator executes the command.
    always_comb begin
        resp_next        = RESP_NONE;
        red_next         = red_reg;
        green_next       = green_reg;
        blue_next        = blue_reg;
        demo_next        = demo_reg;
        set_red_next     = set_red_reg;
        set_green_next   = set_green_reg;
        set_blue_next    = set_blue_reg;
        fade_ctl.tick    = advance && cmd_reg && demo_reg;
        fade_ctl.restart = 1'b0;

        if (advance) begin
            if (cmd_reg) begin
                if (demo_reg) begin
                    red_next   = fade_out.mask[0] ? fade_out.level : '0;
                    green_next = fade_out.mask[1] ? fade_out.level : '0;
                    blue_next  = fade_out.mask[2] ? fade_out.level : '0;
                end
            end else if (dec.term) begin
                case (dec.kind)
                    CMD_EMPTY: begin
                        resp_next = RESP_NONE;
                    end
                    CMD_DEMO: begin
                        demo_next = !demo_reg;
                        if (!demo_reg) begin
                            // Restart the ramp; hold shown levels until the next tick.
                            fade_ctl.restart = 1'b1;
                            resp_next        = RESP_DEMO_ON;
                        end else begin
                            red_next   = set_red_reg;
                            green_next = set_green_reg;
                            blue_next  = set_blue_reg;
                            resp_next  = RESP_DEMO_OFF;
                        end
                    end
                    default: begin
                        if (demo_reg) begin
                            resp_next = RESP_IGNORED;
                        end else begin
                            case (dec.kind)
                                CMD_RED: begin
                                    set_red_next = dec.value;
                                    resp_next    = RESP_RED_OK;
                                end
                                CMD_GREEN: begin
                                    set_green_next = dec.value;
                                    resp_next      = RESP_GREEN_OK;
                                end
                                CMD_BLUE: begin
                                    set_blue_next = dec.value;
                                    resp_next     = RESP_BLUE_OK;
                                end
                                default: begin
                                    resp_next = RESP_INVALID;
                                end
                            endcase
                            if (resp_next != RESP_INVALID) begin
                                red_next   = set_red_next;
                                green_next = set_green_next;
                                blue_next  = set_blue_next;
                            end
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            resp_reg      <= RESP_NONE;
            red_reg       <= '0;
            green_reg     <= '0;
            blue_reg      <= '0;
            demo_reg      <= 1'b0;
            set_red_reg   <= '0;
            set_green_reg <= '0;
            set_blue_reg  <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            resp_reg      <= advance ? resp_next : resp_reg;
            red_reg       <= red_next;
            green_reg     <= green_next;
            blue_reg      <= blue_next;
            demo_reg      <= demo_next;
            set_red_reg   <= set_red_next;
            set_green_reg <= set_green_next;
            set_blue_reg  <= set_blue_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_red_level   = red_reg;
    assign m_green_level = green_reg;
    assign m_blue_level  = blue_reg;
    assign m_response    = resp_reg;
    assign m_demo_active = demo_reg;

endmodule

/* rtl/rlcf_cmd.sv */
// Command buffer: collects characters and decodes the held command.
// Depends on rlcf_pkg.
module rlcf_cmd
    import rlcf_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       step,
    input  logic [7:0] char_code,
    output cmd_dec_t   dec
);

    localparam int unsigned LEN_W = $clog2(BUFFER_DEPTH + 1);
    localparam logic [LEN_W-1:0] DEPTH_LEN = LEN_W'(BUFFER_DEPTH);
    localparam int unsigned KEEP = 3;

    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       bytes_reg [KEEP];
    logic             is_term;
    logic             dig1, dig2;
    logic [3:0]       d1, d2;
    logic [7:0]       c0;

    assign is_term = (char_code == CHAR_LF) || (char_code == CHAR_CR);

    always_comb begin
        len_next = len_reg;
        if (step) begin
            if (is_term) begin
                len_next = '0;
            end else if (len_reg < DEPTH_LEN) begin
                len_next = len_reg + LEN_W'(1);
            end else begin
                len_next = '0;  // overflow: drop the whole command
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg <= '0;
        end else begin
            len_reg <= len_next;
        end
    end

    // Only the first three bytes can form a valid command; later ones only count.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < KEEP; i++) begin
            if (step && !is_term && len_reg == LEN_W'(i)) begin
                bytes_reg[i] <= char_code;
            end
        end
    end

    assign c0   = bytes_reg[0];
    assign dig1 = (bytes_reg[1] >= CHAR_ZERO) && (bytes_reg[1] <= CHAR_NINE);
    assign dig2 = (bytes_reg[2] >= CHAR_ZERO) && (bytes_reg[2] <= CHAR_NINE);
    assign d1   = bytes_reg[1][3:0];
    assign d2   = bytes_reg[2][3:0];

    always_comb begin
        dec.term  = is_term;
        dec.value = {d1, 3'b000} + {2'b00, d1, 1'b0} + {3'b000, d2};
        if (len_reg == '0) begin
            dec.kind = CMD_EMPTY;
        end else if (len_reg == LEN_W'(1) && (c0 == CHAR_D_LOW || c0 == CHAR_D_UP)) begin
            dec.kind = CMD_DEMO;
        end else if (len_reg == LEN_W'(3) && dig1 && dig2) begin
            if (c0 == CHAR_R_LOW || c0 == CHAR_R_UP) begin
                dec.kind = CMD_RED;
            end else if (c0 == CHAR_G_LOW || c0 == CHAR_G_UP) begin
                dec.kind = CMD_GREEN;
            end else if (c0 == CHAR_B_LOW || c0 == CHAR_B_UP) begin
                dec.kind = CMD_BLUE;
            end else begin
                dec.kind = CMD_BAD;
            end
        end else begin
            dec.kind = CMD_BAD;
        end
    end

endmodule

/* rtl/rlcf_fade.sv */
// Demo fade generator: brightness ramp and colour mask sequencing.
// Depends on rlcf_pkg.
module rlcf_fade
    import rlcf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  fade_ctl_t ctl,
    output fade_out_t fout
);

    logic [LEVEL_W-1:0] level_reg, level_next;
    logic               rising_reg, rising_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;

    always_comb begin
        level_next  = level_reg;
        rising_next = rising_reg;
        idx_next    = idx_reg;
        if (ctl.restart) begin
            level_next  = '0;
            rising_next = 1'b1;
            idx_next    = '0;
        end else if (ctl.tick) begin
            if (rising_reg) begin
                if (level_reg >= LEVEL_PRE_MAX) begin
                    level_next  = LEVEL_MAX;
                    rising_next = 1'b0;
                end else begin
                    level_next = level_reg + LEVEL_W'(1);
                end
            end else begin
                if (level_reg <= LEVEL_W'(1)) begin
                    level_next  = '0;
                    rising_next = 1'b1;
                    idx_next    = (idx_reg == LAST_MASK_IDX) ? '0 : idx_reg + IDX_W'(1);
                end else begin
                    level_next = level_reg - LEVEL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg  <= '0;
            rising_reg <= 1'b1;
            idx_reg    <= '0;
        end else begin
            level_reg  <= level_next;
            rising_reg <= rising_next;
            idx_reg    <= idx_next;
        end
    end

    assign fout.level = level_next;
    assign fout.mask  = colour_mask(idx_next);

endmodule

/* sim/rlcf_led_checker.sv */
// Scoreboard for the RGB LED command and fade block: predicts every result
// from the input transactions and compares it with what the block returns.
// Depends on rlcf_pkg for widths, character codes and response codes.
module rlcf_led_checker
    import rlcf_pkg::*;
#(
    parameter int unsigned BUFFER_DEPTH = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_command,
    input  logic [7:0]         s_char_code,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [LEVEL_W-1:0] m_red_level,
    input  logic [LEVEL_W-1:0] m_green_level,
    input  logic [LEVEL_W-1:0] m_blue_level,
    input  logic [RESP_W-1:0]  m_response,
    input  logic               m_demo_active,
    output int                 mismatches,
    output int                 results_pending,
    output logic               model_demo_on
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
        resp_t              response;
        logic               demo;
    } led_result_t;

    // Fade colour order, entry 0 in the low bits: bit 0 red, 1 green, 2 blue.
    localparam logic [20:0] FADE_MASKS = {3'b111, 3'b101, 3'b110, 3'b011,
                                          3'b100, 3'b010, 3'b001};

    logic [7:0]         line_buf [BUFFER_DEPTH];
    int unsigned        line_len;
    logic [LEVEL_W-1:0] duty [3];
    logic [LEVEL_W-1:0] shown [3];
    logic [LEVEL_W-1:0] fade_lvl;
    logic               fade_up;
    logic [IDX_W-1:0]   mask_idx;
    logic               demo;
    led_result_t        expected_leds [$];
    int                 fail_total;

    task automatic show_duties();
        for (int k = 0; k < 3; k++) shown[k] = duty[k];
    endtask

    function automatic bit is_decimal(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    task automatic fade_step();
        logic [2:0] mask;
        if (!demo) return;
        if (fade_up) begin
            if (fade_lvl + 1 >= LEVEL_MAX) begin
                fade_lvl = LEVEL_MAX;
                fade_up  = 1'b0;
            end else begin
                fade_lvl = fade_lvl + 1'b1;
            end
        end else if (fade_lvl <= 1) begin
            fade_lvl = '0;
            fade_up  = 1'b1;
            mask_idx = (mask_idx == LAST_MASK_IDX) ? '0 : mask_idx + 1'b1;
        end else begin
            fade_lvl = fade_lvl - 1'b1;
        end
        mask = FADE_MASKS[mask_idx*3 +: 3];
        for (int k = 0; k < 3; k++) shown[k] = mask[k] ? fade_lvl : '0;
    endtask

    task automatic decode_line(output resp_t resp);
        int value;
        resp = RESP_NONE;
        if (line_len == 0) return;
        if (line_len == 1 && (line_buf[0] == CHAR_D_LOW || line_buf[0] == CHAR_D_UP)) begin
            demo = !demo;
            if (demo) begin
                fade_lvl = '0;
                fade_up  = 1'b1;
                mask_idx = '0;
                resp     = RESP_DEMO_ON;
            end else begin
                show_duties();
                resp = RESP_DEMO_OFF;
            end
            return;
        end
        if (demo) begin
            resp = RESP_IGNORED;
            return;
        end
        resp = RESP_INVALID;
        if (line_len == 3 && is_decimal(line_buf[1]) && is_decimal(line_buf[2])) begin
            value = (line_buf[1] - CHAR_ZERO) * 10 + (line_buf[2] - CHAR_ZERO);
            case (line_buf[0])
                CHAR_R_LOW, CHAR_R_UP: begin
                    duty[0] = value[LEVEL_W-1:0];
                    resp    = RESP_RED_OK;
                end
                CHAR_G_LOW, CHAR_G_UP: begin
                    duty[1] = value[LEVEL_W-1:0];
                    resp    = RESP_GREEN_OK;
                end
                CHAR_B_LOW, CHAR_B_UP: begin
                    duty[2] = value[LEVEL_W-1:0];
                    resp    = RESP_BLUE_OK;
                end
                default: ;
            endcase
            if (resp != RESP_INVALID) show_duties();
        end
    endtask

    task automatic predict_leds(input logic is_tick, input logic [7:0] code,
                                output led_result_t r);
        resp_t resp;
        resp = RESP_NONE;
        if (is_tick) begin
            fade_step();
        end else if (code == CHAR_LF || code == CHAR_CR) begin
            decode_line(resp);
            line_len = 0;
        end else if (line_len < BUFFER_DEPTH) begin
            line_buf[line_len] = code;
            line_len++;
        end else begin
            // Overlong command: drop it along with this character.
            line_len = 0;
        end
        r.red      = shown[0];
        r.green    = shown[1];
        r.blue     = shown[2];
        r.response = resp;
        r.demo     = demo;
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            fail_total++;
        end
    endtask

    always @(posedge aclk) begin : scoreboard
        led_result_t want;
        if (!aresetn) begin
            line_len = 0;
            for (int k = 0; k < 3; k++) begin
                duty[k]  = '0;
                shown[k] = '0;
            end
            fade_lvl = '0;
            fade_up  = 1'b1;
            mask_idx = '0;
            demo     = 1'b0;
            expected_leds.delete();
        end else begin
            // Compare before predicting: a result never leaves in its own cycle.
            if (m_valid && m_ready) begin
                if (expected_leds.size() == 0) begin
                    $error("result transaction with no input outstanding");
                    fail_total++;
                end else begin
                    want = expected_leds.pop_front();
                    check_field("red_level", 8'(want.red), 8'(m_red_level));
                    check_field("green_level", 8'(want.green), 8'(m_green_level));
                    check_field("blue_level", 8'(want.blue), 8'(m_blue_level));
                    check_field("response", 8'(want.response), 8'(m_response));
                    check_field("demo_active", 8'(want.demo), 8'(m_demo_active));
                end
            end
            if (s_valid && s_ready) begin
                predict_leds(s_command, s_char_code, want);
                expected_leds.push_back(want);
            end
        end
        mismatches      <= fail_total;
        results_pending <= expected_leds.size();
        model_demo_on   <= demo;
    end

endmodule

/* sim/tb_top.sv */
// Top of the RGB LED command and fade testbench: clock, reset, stimulus,
// random back-pressure and the verdict. Depends on rlcf_pkg, the block and
// rlcf_led_checker, which does all prediction and comparison.
module tb_top
    import rlcf_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 12;
    localparam int BUF_DEPTH    = 8;
    localparam int MIXED_ITEMS  = 540;      // random command traffic
    localparam int SWEEP_TICKS  = 600;      // several masks, both ramp ends
    localparam int HOLD_CYCLES  = 200;      // long receiver hold-off
    localparam int HOLD_AT_ITEM = 300;
    localparam int TAIL_CYCLES  = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_command;
    logic [7:0]         s_char_code;
    logic               m_valid;
    logic               m_ready;
    logic [LEVEL_W-1:0] m_red_level;
    logic [LEVEL_W-1:0] m_green_level;
    logic [LEVEL_W-1:0] m_blue_level;
    logic [RESP_W-1:0]  m_response;
    logic               m_demo_active;

    int                 mismatches;
    int                 results_pending;
    logic               model_demo_on;

    // Stimulus control shared with the receiver process.
    bit                 idle_en;
    int                 hold_requests;
    int                 items_sent;
    int                 cycle_count;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    rgb_led_command_and_fade #(
        .BUFFER_DEPTH (BUF_DEPTH)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_char_code   (s_char_code),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red_level   (m_red_level),
        .m_green_level (m_green_level),
        .m_blue_level  (m_blue_level),
        .m_response    (m_response),
        .m_demo_active (m_demo_active)
    );

    rlcf_led_checker #(
        .BUFFER_DEPTH (BUF_DEPTH)
    ) led_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_char_code     (s_char_code),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_red_level     (m_red_level),
        .m_green_level   (m_green_level),
        .m_blue_level    (m_blue_level),
        .m_response      (m_response),
        .m_demo_active   (m_demo_active),
        .mismatches      (mismatches),
        .results_pending (results_pending),
        .model_demo_on   (model_demo_on)
    );

    // Watchdog: stop a hung run well past the slowest legal schedule.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: short random stall bursts while idling is on, plus one long
    // hold-off on request so the block fills up and drops s_ready.
    initial begin : receiver
        int stall_left;
        int holds_served;
        stall_left   = 0;
        holds_served = 0;
        m_ready      = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (idle_en && $urandom_range(0, 5) == 0) begin
                // Random stall burst, starting with this one.
                m_ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one transaction; entered and left right after a falling edge.
    // An optional gap drops valid first; then hold valid and
    // the payload until the block takes the transaction.
    task automatic send_item(input logic is_tick, input logic [7:0] code);
        int gap;
        if (idle_en && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_command   <= is_tick;
        s_char_code <= code;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        items_sent++;
    endtask

    task automatic send_text(input string txt);
        for (int k = 0; k < txt.len(); k++) send_item(1'b0, txt[k]);
    endtask

    // Drop valid and let every outstanding result come back.
    task automatic drain();
        s_valid <= 1'b0;
        while (results_pending != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF || b == CHAR_CR);
        return b;
    endfunction

    function automatic logic [7:0] pick_terminator();
        return $urandom_range(0, 1) ? CHAR_LF : CHAR_CR;
    endfunction

    function automatic logic [7:0] pick_digit();
        logic [7:0] d;
        d = CHAR_ZERO + 8'($urandom_range(0, 9));
        return d;
    endfunction

    // Mostly a real digit; sometimes the codes just outside '0'..'9'.
    function automatic logic [7:0] near_digit();
        case ($urandom_range(0, 7))
            0:       return CHAR_ZERO - 8'd1;
            1:       return CHAR_NINE + 8'd1;
            default: return pick_digit();
        endcase
    endfunction

    // One random command-shaped chunk of traffic. Well-formed colour and demo
    // commands are the largest share; the rest are fade tick runs, overlong and malformed
    // commands, unknown letters and single noise transactions.
    task automatic random_sequence();
        int         kind;
        int         n;
        logic [7:0] letter;
        kind = $urandom_range(0, 99);
        if (kind < 35) begin
            case ($urandom_range(0, 5))
                0:       letter = CHAR_R_LOW;
                1:       letter = CHAR_R_UP;
                2:       letter = CHAR_G_LOW;
                3:       letter = CHAR_G_UP;
                4:       letter = CHAR_B_LOW;
                default: letter = CHAR_B_UP;
            endcase
            send_item(1'b0, letter);
            send_item(1'b0, near_digit());
            send_item(1'b0, near_digit());
            send_item(1'b0, pick_terminator());
        end else if (kind < 45) begin
            send_item(1'b0, $urandom_range(0, 1) ? CHAR_D_LOW : CHAR_D_UP);
            send_item(1'b0, pick_terminator());
        end else if (kind < 65) begin
            // Mostly short runs; some long enough to reach full brightness.
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 220)
                                            : $urandom_range(1, 30);
            repeat (n) send_item(1'b1, 8'($urandom_range(0, 255)));
        end else if (kind < 72) begin
            // Past the buffer depth: the command is thrown away, later
            // characters start a fresh one.
            n = $urandom_range(BUF_DEPTH + 1, BUF_DEPTH + 4);
            repeat (n) send_item(1'b0, plain_byte());
            send_item(1'b0, pick_terminator());
        end else if (kind < 77) begin
            // Exactly full buffer, still interpreted.
            repeat (BUF_DEPTH) send_item(1'b0, plain_byte());
            send_item(1'b0, pick_terminator());
        end else if (kind < 87) begin
            n = $urandom_range(1, BUF_DEPTH - 1);
            repeat (n) begin
                case ($urandom_range(0, 3))
                    0:       send_item(1'b0, pick_digit());
                    1:       send_item(1'b0, CHAR_D_LOW);
                    2:       send_item(1'b0, CHAR_G_UP);
                    default: send_item(1'b0, plain_byte());
                endcase
            end
            send_item(1'b0, pick_terminator());
        end else if (kind < 92) begin
            // Valid digits behind an arbitrary letter.
            send_item(1'b0, plain_byte());
            send_item(1'b0, pick_digit());
            send_item(1'b0, pick_digit());
            send_item(1'b0, pick_terminator());
        end else begin
            send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        int  next_idle_change;
        bit  hold_done;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_command     = 1'b0;
        s_char_code   = '0;
        idle_en       = 1'b1;
        hold_requests = 0;
        items_sent    = 0;
        hold_done     = 1'b0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: tick with demo off (carrying a newline code that must be
        // ignored), empty command, duty extremes, invalid bytes at both ends
        // of the code range, demo on, colour command refused in demo, ticks
        // in demo, demo off restoring the set duties.
        send_item(1'b1, CHAR_LF);
        send_item(1'b0, CHAR_LF);
        send_text("R99");
        send_item(1'b0, CHAR_CR);
        send_text("g00");
        send_item(1'b0, CHAR_LF);
        send_text("b57");
        send_item(1'b0, CHAR_LF);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, 8'h00);
        send_item(1'b0, CHAR_LF);
        send_text("d");
        send_item(1'b0, CHAR_LF);
        send_text("r12");
        send_item(1'b0, CHAR_LF);
        send_item(1'b1, 8'hFF);
        send_item(1'b1, CHAR_CR);
        send_text("D");
        send_item(1'b0, CHAR_CR);

        // Random command traffic with idling switched on and off in stretches.
        next_idle_change = items_sent + 80;
        while (items_sent < MIXED_ITEMS) begin
            if (items_sent >= next_idle_change) begin
                idle_en          = ($urandom_range(0, 3) != 0);
                next_idle_change = items_sent + 80;
            end
            if (!hold_done && items_sent >= HOLD_AT_ITEM) begin
                hold_requests++;
                hold_done = 1'b1;
            end
            random_sequence();
        end

        // Final stretch, no idling: flush any partial command, force demo on,
        // then tick long enough for the fade to run through several masks.
        idle_en = 1'b0;
        send_item(1'b0, CHAR_LF);
        send_item(1'b0, CHAR_CR);
        drain();
        if (!model_demo_on) begin
            send_item(1'b0, CHAR_D_LOW);
            send_item(1'b0, CHAR_LF);
        end
        repeat (SWEEP_TICKS) send_item(1'b1, 8'($urandom_range(0, 255)));
        s_valid <= 1'b0;

        while (results_pending != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/rlcf_pkg.sv
rtl/rlcf_cmd.sv
rtl/rlcf_fade.sv
rtl/rgb_led_command_and_fade.sv
sim/rlcf_led_checker.sv
sim/tb_top.sv
